// File: src/u8gw_pkg.sv
package u8gw_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int CODE_W   = 16;
   localparam int WIDTH_W  = 8;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int SCREEN_W = 12;
   localparam int TOTAL_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int ENTRY_W  = CODE_W + WIDTH_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] REG_GLYPH_COUNT  = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_WIDTH = 4'd1;

   localparam logic [SCREEN_W-1:0] SCREEN_RESET = 12'd256;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TEXT  = 1'b1;

   typedef struct packed {
      logic [1:0]        cnt;
      logic [CODE_W-1:0] code0;
      logic [CODE_W-1:0] code1;
      logic [CODE_W-1:0] pend;
      logic [1:0]        expect_cnt;
   } dec_type;

endpackage

// File: src/u8gw_req_if.sv
interface u8gw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [u8gw_pkg::INDEX_W-1:0]  entry_index;
   logic [u8gw_pkg::CODE_W-1:0]   entry_code;
   logic [u8gw_pkg::WIDTH_W-1:0]  entry_width;
   logic [u8gw_pkg::BYTE_W-1:0]   text_byte;
   logic                          string_end;

   modport source (output valid, opcode, entry_index, entry_code, entry_width, text_byte,
                   string_end, input ready);
   modport sink (input valid, opcode, entry_index, entry_code, entry_width, text_byte,
                 string_end, output ready);
endinterface

// File: src/u8gw_rsp_if.sv
interface u8gw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                glyph_valid;
   logic [u8gw_pkg::INDEX_W-1:0]        glyph_index;
   logic [u8gw_pkg::WIDTH_W-1:0]        glyph_width;
   logic [u8gw_pkg::TOTAL_W-1:0]        total_width;
   logic signed [u8gw_pkg::TOTAL_W-1:0] centered_x;
   logic                                text_done;
   logic                                run_last;

   modport source (output valid, glyph_valid, glyph_index, glyph_width, total_width,
                   centered_x, text_done, run_last, input ready);
   modport sink (input valid, glyph_valid, glyph_index, glyph_width, total_width,
                 centered_x, text_done, run_last, output ready);
endinterface

// File: src/u8gw_csr_if.sv
interface u8gw_csr_if;
   logic                             valid;
   logic                             ready;
   logic [u8gw_pkg::CSR_ADDR_W-1:0]  addr;
   logic [u8gw_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// File: src/u8gw_glyph_ram.sv
module u8gw_glyph_ram #(
   parameter int TABLE_DEPTH = u8gw_pkg::TABLE_DEPTH_DEF,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [u8gw_pkg::ENTRY_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [u8gw_pkg::ENTRY_W-1:0]  rd_data
);

   logic [u8gw_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [u8gw_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/u8gw_decode.sv
module u8gw_decode (
   input  logic [u8gw_pkg::BYTE_W-1:0]  text_byte,
   input  logic                         string_end,
   input  logic [u8gw_pkg::CODE_W-1:0]  pend,
   input  logic [1:0]                   expect_cnt,
   output u8gw_pkg::dec_type            dec
);

   always_comb begin
      logic [1:0]                  be_dec;
      logic [u8gw_pkg::CODE_W-1:0] merged;

      dec = '0;
      be_dec = expect_cnt - 2'd1;
      merged = pend;

      if (expect_cnt != 2'd0 && text_byte[7:6] == 2'b10) begin
         case (be_dec)
            2'd0:    merged = pend | {10'b0, text_byte[5:0]};
            2'd1:    merged = pend | {4'b0, text_byte[5:0], 6'b0};
            2'd2:    merged = pend | {text_byte[3:0], 12'b0};
            default: merged = pend;
         endcase
         if (be_dec == 2'd0) begin
            dec.code0 = merged;
            dec.cnt = 2'd1;
         end else begin
            dec.pend = merged;
            dec.expect_cnt = be_dec;
         end
      end else begin
         if (expect_cnt != 2'd0) begin
            dec.code0 = pend;
            dec.cnt = 2'd1;
         end
         if (text_byte[7] == 1'b0) begin
            if (dec.cnt == 2'd0) begin
               dec.code0 = {8'b0, text_byte};
            end else begin
               dec.code1 = {8'b0, text_byte};
            end
            dec.cnt = dec.cnt + 2'd1;
         end else if (text_byte[7:5] == 3'b110) begin
            dec.pend = {5'b0, text_byte[4:0], 6'b0};
            dec.expect_cnt = 2'd1;
         end else if (text_byte[7:4] == 4'b1110) begin
            dec.pend = {text_byte[3:0], 12'b0};
            dec.expect_cnt = 2'd2;
         end else if (text_byte[7:3] == 5'b11110) begin
            dec.pend = '0;
            dec.expect_cnt = 2'd3;
         end
      end

      if (string_end) begin
         if (dec.expect_cnt != 2'd0) begin
            if (dec.cnt == 2'd0) begin
               dec.code0 = dec.pend;
            end else begin
               dec.code1 = dec.pend;
            end
            dec.cnt = dec.cnt + 2'd1;
         end
         dec.pend = '0;
         dec.expect_cnt = 2'd0;
      end
   end

endmodule

// File: src/utf8_glyph_width_measure_top.sv
// Decodes a UTF-8 byte stream (opcode 1) and looks each character up by binary
// search in a glyph table loaded with opcode 0 transactions, giving up to two
// result transactions per byte with the running saturated width and, on the
// last result of a string, the centered left x. Each glyph that a text byte
// yields costs a search of at most ceil(log2(glyph_count+1)) steps, each one
// table read and one compare on the single table read port, then a width read
// and the result hand-off. The block takes no new transaction until all results
// of the current one are loaded into the output register; configuration writes
// are taken at any time.
module utf8_glyph_width_measure_top #(
   parameter int TABLE_DEPTH = u8gw_pkg::TABLE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   u8gw_csr_if.sink   csr_chan,
   u8gw_req_if.sink   req_chan,
   u8gw_rsp_if.source rsp_chan
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_WREAD = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [u8gw_pkg::COUNT_W-1:0]   glyph_count_ff;
   logic [u8gw_pkg::SCREEN_W-1:0]  screen_ff;
   logic [u8gw_pkg::CODE_W-1:0]    pend_ff, pend_in;
   logic [1:0]                     be_ff, be_in;
   logic [u8gw_pkg::TOTAL_W-1:0]   run_ff, run_in;
   logic [u8gw_pkg::CODE_W-1:0]    code0_ff, code0_in;
   logic [u8gw_pkg::CODE_W-1:0]    code1_ff, code1_in;
   logic [1:0]                     cnt_ff, cnt_in;
   logic                           pos_ff, pos_in;
   logic                           end_ff, end_in;
   logic [CW-1:0]                  lo_ff, lo_in;
   logic [CW-1:0]                  hiex_ff, hiex_in;
   logic [AW-1:0]                  mid_ff, mid_in;
   logic [AW-1:0]                  idx_ff, idx_in;

   logic                           out_valid_ff, out_valid_in;
   logic                           out_gv_ff, out_gv_in;
   logic [u8gw_pkg::INDEX_W-1:0]   out_idx_ff, out_idx_in;
   logic [u8gw_pkg::WIDTH_W-1:0]   out_w_ff, out_w_in;
   logic [u8gw_pkg::TOTAL_W-1:0]   out_tot_ff, out_tot_in;
   logic [u8gw_pkg::TOTAL_W-1:0]   out_cx_ff, out_cx_in;
   logic                           out_done_ff, out_done_in;
   logic                           out_last_ff, out_last_in;

   u8gw_pkg::dec_type              dec;
   logic                           req_fire;
   logic                           tbl_wr_en;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [u8gw_pkg::ENTRY_W-1:0]   rd_data;
   logic [CW-1:0]                  n_used;
   logic [CW-1:0]                  span;
   logic [CW-1:0]                  mid_c;
   logic [u8gw_pkg::CODE_W-1:0]    cur_code;
   logic [u8gw_pkg::WIDTH_W-1:0]   cur_w;
   logic [u8gw_pkg::TOTAL_W:0]     sum;
   logic [u8gw_pkg::TOTAL_W-1:0]   sat;
   logic [17:0]                    diff;
   logic [17:0]                    diff_adj;
   logic                           out_free;
   logic                           is_last;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign tbl_wr_en = req_fire && (req_chan.opcode == u8gw_pkg::OP_WRITE)
                      && (32'(req_chan.entry_index) < TABLE_DEPTH);

   assign n_used = (32'(glyph_count_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                       : CW'(glyph_count_ff);
   assign span  = hiex_ff - lo_ff - CW'(1);
   assign mid_c = lo_ff + (span >> 1);

   assign rd_en   = (state_ff == S_ISSUE) || (state_ff == S_WREAD);
   assign rd_addr = (state_ff == S_WREAD) ? idx_ff : AW'(mid_c);

   u8gw_glyph_ram #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(req_chan.entry_index)),
      .wr_data ({req_chan.entry_code, req_chan.entry_width}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   u8gw_decode u_dec (
      .text_byte  (req_chan.text_byte),
      .string_end (req_chan.string_end),
      .pend       (pend_ff),
      .expect_cnt (be_ff),
      .dec        (dec)
   );

   assign cur_code = pos_ff ? code1_ff : code0_ff;
   assign cur_w    = (cnt_ff == 2'd0) ? '0 : rd_data[u8gw_pkg::WIDTH_W-1:0];
   assign sum      = {1'b0, run_ff} + {{(u8gw_pkg::TOTAL_W + 1 - u8gw_pkg::WIDTH_W){1'b0}}, cur_w};
   assign sat      = sum[u8gw_pkg::TOTAL_W] ? '1 : sum[u8gw_pkg::TOTAL_W-1:0];
   assign diff     = {6'b0, screen_ff} - {2'b0, sat};
   assign diff_adj = diff + {17'b0, diff[17]};
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign is_last  = (cnt_ff == 2'd0) || ({1'b0, pos_ff} == cnt_ff - 2'd1);

   always_comb begin
      state_in = state_ff;
      pend_in = pend_ff;
      be_in = be_ff;
      run_in = run_ff;
      code0_in = code0_ff;
      code1_in = code1_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      end_in = end_ff;
      lo_in = lo_ff;
      hiex_in = hiex_ff;
      mid_in = mid_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_gv_in = out_gv_ff;
      out_idx_in = out_idx_ff;
      out_w_in = out_w_ff;
      out_tot_in = out_tot_ff;
      out_cx_in = out_cx_ff;
      out_done_in = out_done_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.opcode == u8gw_pkg::OP_TEXT) begin
               pend_in = dec.pend;
               be_in = dec.expect_cnt;
               code0_in = dec.code0;
               code1_in = dec.code1;
               cnt_in = dec.cnt;
               end_in = req_chan.string_end;
               pos_in = 1'b0;
               lo_in = '0;
               hiex_in = n_used;
               if (dec.cnt != 2'd0) begin
                  state_in = S_ISSUE;
               end else if (req_chan.string_end) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_ISSUE: begin
            if (lo_ff < hiex_ff) begin
               mid_in = AW'(mid_c);
               state_in = S_CMP;
            end else begin
               idx_in = '0;
               state_in = S_WREAD;
            end
         end
         S_CMP: begin
            if (rd_data[u8gw_pkg::ENTRY_W-1:u8gw_pkg::WIDTH_W] == cur_code) begin
               idx_in = mid_ff;
               state_in = S_WREAD;
            end else begin
               if (rd_data[u8gw_pkg::ENTRY_W-1:u8gw_pkg::WIDTH_W] < cur_code) begin
                  lo_in = CW'(mid_ff) + CW'(1);
               end else begin
                  hiex_in = CW'(mid_ff);
               end
               state_in = S_ISSUE;
            end
         end
         S_WREAD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_gv_in = (cnt_ff != 2'd0);
               out_idx_in = (cnt_ff != 2'd0) ? u8gw_pkg::INDEX_W'(idx_ff) : '0;
               out_w_in = cur_w;
               out_tot_in = sat;
               out_done_in = is_last && end_ff;
               out_cx_in = (is_last && end_ff) ? diff_adj[16:1] : '0;
               out_last_in = is_last;
               run_in = (is_last && end_ff) ? '0 : sat;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in = 1'b1;
                  lo_in = '0;
                  hiex_in = n_used;
                  state_in = S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= '0;
         be_ff <= '0;
         run_ff <= '0;
         cnt_ff <= '0;
         pos_ff <= 1'b0;
         end_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         glyph_count_ff <= '0;
         screen_ff <= u8gw_pkg::SCREEN_RESET;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         be_ff <= be_in;
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         end_ff <= end_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            case (csr_chan.addr)
               u8gw_pkg::REG_GLYPH_COUNT: begin
                  glyph_count_ff <= csr_chan.data[u8gw_pkg::COUNT_W-1:0];
               end
               u8gw_pkg::REG_SCREEN_WIDTH: begin
                  screen_ff <= csr_chan.data[u8gw_pkg::SCREEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      code0_ff <= code0_in;
      code1_ff <= code1_in;
      lo_ff <= lo_in;
      hiex_ff <= hiex_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
      out_gv_ff <= out_gv_in;
      out_idx_ff <= out_idx_in;
      out_w_ff <= out_w_in;
      out_tot_ff <= out_tot_in;
      out_cx_ff <= out_cx_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.glyph_valid = out_gv_ff;
   assign rsp_chan.glyph_index = out_idx_ff;
   assign rsp_chan.glyph_width = out_w_ff;
   assign rsp_chan.total_width = out_tot_ff;
   assign rsp_chan.centered_x  = $signed(out_cx_ff);
   assign rsp_chan.text_done   = out_done_ff;
   assign rsp_chan.run_last    = out_last_ff;

endmodule
